### rtl/core/ilie_pkg.sv
// ilie_pkg: shared types and constants of the indexed list insert/erase unit
// no dependencies; used by ilie_front, ilie_back and the top level
package ilie_pkg;

	localparam int POS_W       = 5;
	localparam int DATA_W      = 32;
	localparam int EIDX_W      = 4;
	localparam int LEN_W       = 5;
	localparam int CMD_W       = 2;
	localparam int MAX_RESULTS = 16;
	localparam int Q_DEPTH     = 2;

	// command codes on the input port
	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_ERASE  = 2'd1,
		CMD_DUMP   = 2'd2
	} cmd_t;

	// decoded operation, one-hot or all zero for an unused code
	typedef struct packed {
		logic              ins;
		logic              ers;
		logic              dmp;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] value;
	} op_t;

	// one result beat
	typedef struct packed {
		logic              success;
		logic              has_item;
		logic [DATA_W-1:0] entry_value;
		logic [EIDX_W-1:0] entry_index;
		logic [LEN_W-1:0]  list_length;
		logic              last;
	} res_t;

endpackage

### rtl/core/ilie_front.sv
// ilie_front: accepts command beats, decodes them and holds them in a short queue
// depends on ilie_pkg
module ilie_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [ilie_pkg::CMD_W-1:0] command,
	input  logic [ilie_pkg::POS_W-1:0] position,
	input  logic [ilie_pkg::DATA_W-1:0] item_value,
	output logic                       op_valid,
	output ilie_pkg::op_t              op,
	input  logic                       op_pop
);

	localparam int PTR_W = (ilie_pkg::Q_DEPTH > 1) ? $clog2(ilie_pkg::Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(ilie_pkg::Q_DEPTH + 1);

	ilie_pkg::op_t      queue_q [ilie_pkg::Q_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   fill_q;
	ilie_pkg::op_t      dec;
	logic               wr_en;
	logic               rd_en;

	// command decode
	always_comb begin
		dec       = '0;
		dec.pos   = position;
		dec.value = item_value;
		case (command)
			ilie_pkg::CMD_INSERT: dec.ins = 1'b1;
			ilie_pkg::CMD_ERASE:  dec.ers = 1'b1;
			ilie_pkg::CMD_DUMP:   dec.dmp = 1'b1;
			default:              dec.ins = 1'b0;
		endcase
	end

	assign full     = (fill_q == CNT_W'(ilie_pkg::Q_DEPTH));
	assign op_valid = (fill_q != '0);
	assign op       = queue_q[rd_ptr_q];
	assign wr_en    = push && !full;
	assign rd_en    = op_pop && op_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			queue_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(ilie_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(ilie_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				fill_q <= fill_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/ilie_back.sv
// ilie_back: list storage with parallel shift, dump sequencing and result register
// depends on ilie_pkg
module ilie_back #(
	parameter int CAPACITY = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op_valid,
	input  ilie_pkg::op_t op,
	output logic          op_pop,
	output logic          res_valid,
	output ilie_pkg::res_t res,
	input  logic          res_pop
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW    = (CNT_W > ilie_pkg::POS_W) ? CNT_W : ilie_pkg::POS_W;

	logic [ilie_pkg::DATA_W-1:0] entries_q [CAPACITY];
	logic [CNT_W-1:0]            count_q;
	logic [CW-1:0]               idx_q;
	logic                        res_valid_q;
	ilie_pkg::res_t              res_q;

	logic [CW-1:0]    cnt_c;
	logic [CW-1:0]    pos_c;
	logic [CW-1:0]    dump_n;
	logic [CW-1:0]    idx_inc;
	logic             take;
	logic             ins_ok;
	logic             ers_ok;
	logic             dump_fin;
	logic [CNT_W-1:0] count_nxt;
	ilie_pkg::res_t   res_nxt;

	assign cnt_c   = CW'(count_q);
	assign pos_c   = CW'(op.pos);
	assign idx_inc = idx_q + CW'(1);
	assign take    = op_valid && (!res_valid_q || res_pop);

	assign ins_ok   = op.ins && (cnt_c < CW'(CAPACITY)) && (pos_c <= cnt_c);
	assign ers_ok   = op.ers && (cnt_c != '0) && (pos_c < cnt_c);
	assign dump_n   = (cnt_c > CW'(ilie_pkg::MAX_RESULTS)) ? CW'(ilie_pkg::MAX_RESULTS) : cnt_c;
	assign dump_fin = (cnt_c == '0) || (idx_inc == dump_n);
	assign op_pop   = take && (!op.dmp || dump_fin);

	always_comb begin
		count_nxt = count_q;
		if (ins_ok) begin
			count_nxt = count_q + 1'b1;
		end else if (ers_ok) begin
			count_nxt = count_q - 1'b1;
		end
	end

	always_comb begin
		res_nxt             = '0;
		res_nxt.success     = ins_ok || ers_ok || op.dmp;
		res_nxt.has_item    = op.dmp && (cnt_c != '0);
		res_nxt.list_length = ilie_pkg::LEN_W'(count_nxt);
		res_nxt.last        = !op.dmp || dump_fin;
		if (res_nxt.has_item) begin
			res_nxt.entry_value = entries_q[idx_q[IDX_W-1:0]];
			res_nxt.entry_index = idx_q[ilie_pkg::EIDX_W-1:0];
		end
	end

	// list storage: all entries above an insert position or from an erase position up shift in parallel
	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (ins_ok) begin
					if (CW'(i) == pos_c) begin
						entries_q[i] <= op.value;
					end else if (CW'(i) > pos_c && i > 0) begin
						entries_q[i] <= entries_q[(i > 0) ? i - 1 : 0];
					end
				end else if (ers_ok) begin
					if (CW'(i) >= pos_c && i < CAPACITY - 1) begin
						entries_q[i] <= entries_q[(i < CAPACITY - 1) ? i + 1 : i];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q     <= count_nxt;
				res_valid_q <= 1'b1;
				idx_q       <= op_pop ? '0 : idx_inc;
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

### rtl/core/indexed_list_insert_erase_unit.sv
// indexed_list_insert_erase_unit: top level of the fixed-capacity ordered list
// depends on ilie_pkg, ilie_front, ilie_back
//
//  channel  | handshake         | beat contents
//  ---------+-------------------+-----------------------------------------------
//  command  | push / full       | command, position, item_value
//  result   | empty / pop       | success, has_item, entry_value, entry_index,
//           |                   | list_length, last
//
// insert and erase complete in the back end with all entries shifting at once
// a dump gives one result beat per cycle while results are popped, min(length, 16) beats, one for an empty list
// the result register is the only place a finished beat waits; the back end runs
//   whenever that register is free or being popped this cycle
// a two-deep command queue separates front and back; a dump holds its slot while it streams
//   out, so one more command can still be pushed behind it
// reset clears the length, queue and result valid flag; list storage and result contents are not cleared
module indexed_list_insert_erase_unit #(
	parameter int CAPACITY = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// command side
	input  logic                        push,
	output logic                        full,
	input  logic [ilie_pkg::CMD_W-1:0]  command,
	input  logic [ilie_pkg::POS_W-1:0]  position,
	input  logic signed [ilie_pkg::DATA_W-1:0] item_value,
	// result side
	output logic                        empty,
	input  logic                        pop,
	output logic                        success,
	output logic                        has_item,
	output logic signed [ilie_pkg::DATA_W-1:0] entry_value,
	output logic [ilie_pkg::EIDX_W-1:0] entry_index,
	output logic [ilie_pkg::LEN_W-1:0]  list_length,
	output logic                        last
);

	// front to back queue head
	logic           op_valid;
	logic           op_pop;
	ilie_pkg::op_t  op;

	// result register
	logic           res_valid;
	ilie_pkg::res_t res;

	ilie_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.position   (position),
		.item_value (item_value),
		.op_valid   (op_valid),
		.op         (op),
		.op_pop     (op_pop)
	);

	ilie_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op        (op),
		.op_pop    (op_pop),
		.res_valid (res_valid),
		.res       (res),
		.res_pop   (pop && res_valid)
	);

	// result beat fields
	assign empty       = !res_valid;
	assign success     = res.success;
	assign has_item    = res.has_item;
	assign entry_value = res.entry_value;
	assign entry_index = res.entry_index;
	assign list_length = res.list_length;
	assign last        = res.last;

	// back end never retires a command the queue does not hold
	assert property (@(posedge clk) disable iff (!arst_n) op_pop |-> op_valid)
		else $error("back end popped an empty command queue");

	// a full queue always presents a head to the back end
	assert property (@(posedge clk) disable iff (!arst_n) full |-> op_valid)
		else $error("queue full but no head visible");

	// a dumped entry lies inside the list it was read from
	assert property (@(posedge clk) disable iff (!arst_n)
		(CAPACITY <= 16 && !empty && has_item) |->
			(ilie_pkg::LEN_W'(entry_index) < list_length && success))
		else $error("dumped entry index outside list length");

endmodule

### bench/ilie_result_checker.sv
`timescale 1ns / 100ps
// ilie_result_checker: shadow list of the indexed list unit and result beat compare
// depends on ilie_pkg; instantiated beside the unit by tb_indexed_list_insert_erase_unit
module ilie_result_checker #(
	parameter int CAPACITY = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  logic                               full,
	input  logic [ilie_pkg::CMD_W-1:0]         command,
	input  logic [ilie_pkg::POS_W-1:0]         position,
	input  logic signed [ilie_pkg::DATA_W-1:0] item_value,
	input  logic                               empty,
	input  logic                               pop,
	input  logic                               success,
	input  logic                               has_item,
	input  logic signed [ilie_pkg::DATA_W-1:0] entry_value,
	input  logic [ilie_pkg::EIDX_W-1:0]        entry_index,
	input  logic [ilie_pkg::LEN_W-1:0]         list_length,
	input  logic                               last,
	output int                                 fail_count,
	output int                                 beats_outstanding,
	output logic [ilie_pkg::LEN_W-1:0]         shadow_len
);

	logic [ilie_pkg::DATA_W-1:0] shadow_entries [CAPACITY];
	int                          shadow_count;
	ilie_pkg::res_t              beats_due [$];
	ilie_pkg::res_t              oldest_due;

	initial begin
		fail_count        = 0;
		beats_outstanding = 0;
		shadow_len        = '0;
		shadow_count      = 0;
	end

	function automatic ilie_pkg::res_t make_beat(logic ok, logic item,
			logic [ilie_pkg::DATA_W-1:0] value, int index, logic fin);
		ilie_pkg::res_t b;
		b.success     = ok;
		b.has_item    = item;
		b.entry_value = value;
		b.entry_index = index[ilie_pkg::EIDX_W-1:0];
		b.list_length = shadow_count[ilie_pkg::LEN_W-1:0];
		b.last        = fin;
		return b;
	endfunction

	// apply one command to the shadow list and queue the beats it owes
	task automatic model_list_command(logic [ilie_pkg::CMD_W-1:0] cmd,
			logic [ilie_pkg::POS_W-1:0] pos, logic [ilie_pkg::DATA_W-1:0] value);
		int   n;
		logic ok;
		ok = 1'b0;
		if (cmd == ilie_pkg::CMD_DUMP) begin
			if (shadow_count == 0) begin
				beats_due.push_back(make_beat(1'b1, 1'b0, '0, 0, 1'b1));
			end else begin
				n = (shadow_count > ilie_pkg::MAX_RESULTS) ? ilie_pkg::MAX_RESULTS : shadow_count;
				for (int i = 0; i < n; i++)
					beats_due.push_back(make_beat(1'b1, 1'b1, shadow_entries[i], i, i == n - 1));
			end
		end else begin
			if (cmd == ilie_pkg::CMD_INSERT) begin
				if (shadow_count < CAPACITY && int'(pos) <= shadow_count) begin
					for (int i = shadow_count; i > int'(pos); i--)
						shadow_entries[i] = shadow_entries[i - 1];
					shadow_entries[pos] = value;
					shadow_count++;
					ok = 1'b1;
				end
			end else if (cmd == ilie_pkg::CMD_ERASE) begin
				if (shadow_count > 0 && int'(pos) < shadow_count) begin
					for (int i = int'(pos) + 1; i < shadow_count; i++)
						shadow_entries[i - 1] = shadow_entries[i];
					shadow_count--;
					ok = 1'b1;
				end
			end
			// unused code falls through with ok low
			beats_due.push_back(make_beat(ok, 1'b0, '0, 0, 1'b1));
		end
	endtask

	task automatic compare_field(string name, logic [ilie_pkg::DATA_W-1:0] want,
			logic [ilie_pkg::DATA_W-1:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beats_due.delete();
			shadow_count = 0;
			fail_count   = 0;
		end else begin
			if (push && !full)
				model_list_command(command, position, item_value);
			if (pop && !empty) begin
				if (beats_due.size() == 0) begin
					fail_count++;
					$display("%0t: result beat with none expected, actual len %0d value %0h",
						$time, list_length, entry_value);
				end else begin
					oldest_due = beats_due.pop_front();
					compare_field("success", ilie_pkg::DATA_W'(oldest_due.success),
						ilie_pkg::DATA_W'(success));
					compare_field("has_item", ilie_pkg::DATA_W'(oldest_due.has_item),
						ilie_pkg::DATA_W'(has_item));
					compare_field("entry_value", oldest_due.entry_value, entry_value);
					compare_field("entry_index", ilie_pkg::DATA_W'(oldest_due.entry_index),
						ilie_pkg::DATA_W'(entry_index));
					compare_field("list_length", ilie_pkg::DATA_W'(oldest_due.list_length),
						ilie_pkg::DATA_W'(list_length));
					compare_field("last", ilie_pkg::DATA_W'(oldest_due.last),
						ilie_pkg::DATA_W'(last));
				end
			end
		end
		beats_outstanding = beats_due.size();
		shadow_len        = shadow_count[ilie_pkg::LEN_W-1:0];
	end

endmodule

### bench/tb_indexed_list_insert_erase_unit.sv
`timescale 1ns / 100ps
// tb_indexed_list_insert_erase_unit: stimulus and verdict for the indexed list unit
// depends on ilie_pkg, indexed_list_insert_erase_unit and ilie_result_checker
module tb_indexed_list_insert_erase_unit;

	// command code the unit leaves unused
	localparam logic [ilie_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS   = 330;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int HOLD_CYCLES    = 150;

	logic                               clk;
	logic                               arst_n;
	logic                               push;
	logic                               full;
	logic [ilie_pkg::CMD_W-1:0]         command;
	logic [ilie_pkg::POS_W-1:0]         position;
	logic signed [ilie_pkg::DATA_W-1:0] item_value;
	logic                               empty;
	logic                               pop;
	logic                               success;
	logic                               has_item;
	logic signed [ilie_pkg::DATA_W-1:0] entry_value;
	logic [ilie_pkg::EIDX_W-1:0]        entry_index;
	logic [ilie_pkg::LEN_W-1:0]         list_length;
	logic                               last;

	int                                 fail_count;
	int                                 beats_outstanding;
	logic [ilie_pkg::LEN_W-1:0]         shadow_len;
	int                                 idle_cycles;
	int                                 burst_left;

	indexed_list_insert_erase_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.command     (command),
		.position    (position),
		.item_value  (item_value),
		.empty       (empty),
		.pop         (pop),
		.success     (success),
		.has_item    (has_item),
		.entry_value (entry_value),
		.entry_index (entry_index),
		.list_length (list_length),
		.last        (last)
	);

	ilie_result_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.command           (command),
		.position          (position),
		.item_value        (item_value),
		.empty             (empty),
		.pop               (pop),
		.success           (success),
		.has_item          (has_item),
		.entry_value       (entry_value),
		.entry_index       (entry_index),
		.list_length       (list_length),
		.last              (last),
		.fail_count        (fail_count),
		.beats_outstanding (beats_outstanding),
		.shadow_len        (shadow_len)
	);

	// 12 ns period
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// watchdog: too many cycles in a row with no beat moving on either side
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// put one command beat on the port (called right after a falling edge)
	// and hold it until a rising edge takes it
	task automatic drive_item(logic [ilie_pkg::CMD_W-1:0] cmd, logic [ilie_pkg::POS_W-1:0] pos,
			logic [ilie_pkg::DATA_W-1:0] value);
		push       <= 1'b1;
		command    <= cmd;
		position   <= pos;
		item_value <= value;
		do
			@(posedge clk);
		while (full);
	endtask

	// burst bookkeeping: at the end of a burst drop push for a random gap,
	// with junk on the payload ports so nothing leaks through an idle cycle
	task automatic pace_sender();
		int gap;
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			for (int g = 0; g < gap; g++) begin
				@(negedge clk);
				push       <= 1'b0;
				command    <= ilie_pkg::CMD_W'($urandom_range(0, 3));
				position   <= ilie_pkg::POS_W'($urandom_range(0, 31));
				item_value <= $urandom;
			end
			burst_left = $urandom_range(1, 24);
		end
	endtask

	task automatic offer(logic [ilie_pkg::CMD_W-1:0] cmd, logic [ilie_pkg::POS_W-1:0] pos,
			logic [ilie_pkg::DATA_W-1:0] value);
		@(negedge clk);
		drive_item(cmd, pos, value);
		pace_sender();
	endtask

	// result side: stall pattern of its own, in segments, with two long hold-offs
	// so the command queue fills and full comes up
	initial begin
		int cyc;
		int seg_left;
		int mode;
		int hold_left;
		pop       = 1'b0;
		cyc       = 0;
		seg_left  = 0;
		mode      = 0;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc == 350 || cyc == 1000)
				hold_left = HOLD_CYCLES;
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				if (seg_left <= 0) begin
					mode     = $urandom_range(0, 3);
					seg_left = $urandom_range(10, 60);
				end
				seg_left--;
				case (mode)
					0: pop <= 1'b1;
					1: pop <= ($urandom_range(0, 1) == 1);
					2: pop <= (cyc % 3 == 0);
					default: pop <= ($urandom_range(0, 99) < 85);
				endcase
			end
		end
	end

	// command side
	initial begin
		logic [ilie_pkg::CMD_W-1:0]  cmd;
		logic [ilie_pkg::POS_W-1:0]  pos;
		logic [ilie_pkg::DATA_W-1:0] value;
		int                          pick;
		int                          len;
		bit                          filling;

		push       = 1'b0;
		command    = '0;
		position   = '0;
		item_value = '0;
		arst_n     = 1'b0;
		burst_left = $urandom_range(1, 24);
		filling    = 1'b0;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// directed: empty list corners first
		offer(ilie_pkg::CMD_DUMP, 5'd0, 32'h0);           // dump of an empty list
		offer(ilie_pkg::CMD_ERASE, 5'd0, 32'h0);          // erase from an empty list
		offer(ilie_pkg::CMD_INSERT, 5'd1, 32'h1234_5678); // insert past the length
		offer(ilie_pkg::CMD_INSERT, 5'd0, 32'h7fff_ffff);
		offer(ilie_pkg::CMD_INSERT, 5'd0, 32'h8000_0000);
		offer(ilie_pkg::CMD_INSERT, 5'd2, 32'hffff_ffff); // insert at the length, appends
		offer(CMD_UNUSED, 5'd31, 32'hdead_beef);
		offer(ilie_pkg::CMD_ERASE, 5'd3, 32'h0);          // erase at the length
		offer(ilie_pkg::CMD_ERASE, 5'd1, 32'h0);          // erase from the middle

		// fill up at varying positions, two entries left from above
		for (int k = 0; k < 14; k++)
			offer(ilie_pkg::CMD_INSERT, ilie_pkg::POS_W'((k * 7) % (k + 3)), $urandom);
		offer(ilie_pkg::CMD_INSERT, 5'd16, 32'h5555_aaaa); // insert into a full list
		offer(ilie_pkg::CMD_DUMP, 5'd0, 32'h0);            // sixteen beats
		offer(ilie_pkg::CMD_ERASE, 5'd15, 32'h0);          // last entry

		// random: alternate fill and drain phases so the length sweeps the range
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			@(negedge clk);
			if (n % 40 == 0)
				filling = ~filling;
			len  = int'(shadow_len);
			pick = $urandom_range(0, 99);
			if (filling)
				cmd = (pick < 60) ? ilie_pkg::CMD_INSERT : (pick < 85) ? ilie_pkg::CMD_ERASE :
					(pick < 96) ? ilie_pkg::CMD_DUMP : CMD_UNUSED;
			else
				cmd = (pick < 25) ? ilie_pkg::CMD_INSERT : (pick < 80) ? ilie_pkg::CMD_ERASE :
					(pick < 96) ? ilie_pkg::CMD_DUMP : CMD_UNUSED;

			// mostly legal positions, the rest anywhere in the field
			if ($urandom_range(0, 99) < 85) begin
				if (cmd == ilie_pkg::CMD_INSERT)
					pos = ilie_pkg::POS_W'($urandom_range(0, len));
				else
					pos = (len == 0) ? '0 : ilie_pkg::POS_W'($urandom_range(0, len - 1));
			end else begin
				pos = ilie_pkg::POS_W'($urandom_range(0, 31));
			end

			pick = $urandom_range(0, 99);
			value = (pick < 8) ? 32'h8000_0000 : (pick < 16) ? 32'h7fff_ffff :
				(pick < 20) ? 32'h0 : $urandom;

			drive_item(cmd, pos, value);
			pace_sender();
		end

		@(negedge clk);
		push <= 1'b0;

		// let every owed beat drain, then watch a while for strays
		while (beats_outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0 && beats_outstanding == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

### filelist.f
rtl/core/ilie_pkg.sv
rtl/core/ilie_front.sv
rtl/core/ilie_back.sv
rtl/core/indexed_list_insert_erase_unit.sv
bench/ilie_result_checker.sv
bench/tb_indexed_list_insert_erase_unit.sv
